/* rtl/pbt_pkg.sv */
package pbt_pkg;

    // Table geometry
    localparam int ENTRIES    = 8;
    localparam int PAGE_BITS  = 12;
    localparam int BLOCK_BITS = 6;
    localparam int SIG_BITS   = 12;

    // Fixed field widths of the transactions
    localparam int OP_W   = 2;
    localparam int ADDR_W = 12;
    localparam int SIGF_W = 12;
    localparam int CONF_W = 7;
    localparam int DLT_W  = 7;

    localparam int OFF_BITS = PAGE_BITS - BLOCK_BITS;
    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CLEAR  = 2'd2
    } pbt_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } pbt_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } pbt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_hold;
    } pbt_stat_t;

    // Block offset within the page
    function automatic logic [OFF_BITS-1:0] block_offset(input logic [ADDR_W-1:0] address);
        logic [31:0] a32;
        logic [31:0] mask;
        mask = (32'd1 << PAGE_BITS) - 32'd1;
        a32  = 32'(address) & mask;
        return a32[BLOCK_BITS +: OFF_BITS];
    endfunction

endpackage

/* rtl/pbt_if.sv */
interface pbt_req_if;
    logic                          valid;
    logic                          ready;
    logic [pbt_pkg::OP_W-1:0]      operation;
    logic [pbt_pkg::ADDR_W-1:0]    address;
    logic [pbt_pkg::SIGF_W-1:0]    signature;
    logic [pbt_pkg::CONF_W-1:0]    confidence;
    logic signed [pbt_pkg::DLT_W-1:0] delta;

    modport source (output valid, operation, address, signature, confidence, delta,
                    input ready);
    modport sink   (input valid, operation, address, signature, confidence, delta,
                    output ready);
endinterface

interface pbt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [pbt_pkg::SIGF_W-1:0]    hit_signature;
    logic [pbt_pkg::CONF_W-1:0]    hit_confidence;
    logic signed [pbt_pkg::DLT_W-1:0] hit_delta;

    modport source (output valid, hit, hit_signature, hit_confidence, hit_delta,
                    input ready);
    modport sink   (input valid, hit, hit_signature, hit_confidence, hit_delta,
                    output ready);
endinterface

/* rtl/pbt_ctrl.sv */
module pbt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pbt_pkg::pbt_stat_t stat,
    output pbt_pkg::pbt_cmd_t  cmd
);

    pbt_pkg::pbt_state_t state_reg;
    pbt_pkg::pbt_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: take a transaction, then execute once the result slot frees
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = pbt_pkg::ST_EXEC;
                end
            end
            pbt_pkg::ST_EXEC:
            begin
                if (!stat.out_hold)
                begin
                    state_next = pbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            pbt_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            pbt_pkg::ST_EXEC:
            begin
                cmd.execute = !stat.out_hold;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Never execute into an occupied result slot
    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !stat.out_hold)
        else $error("execute while result slot held");

    // A captured transaction is executed from the next state
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == pbt_pkg::ST_EXEC)
        else $error("capture not followed by execute state");

    // No capture while a transaction is pending
    a_no_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pbt_pkg::ST_EXEC |-> !cmd.capture && !req_ready)
        else $error("capture during execute");

endmodule

/* rtl/pbt_dp.sv */
module pbt_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  pbt_pkg::pbt_cmd_t  cmd,
    output pbt_pkg::pbt_stat_t stat,
    pbt_req_if.sink            req,
    pbt_rsp_if.source          rsp
);

    // Captured transaction
    logic [pbt_pkg::OP_W-1:0]         op_reg;
    logic [pbt_pkg::OFF_BITS-1:0]     off_reg;
    logic [pbt_pkg::SIG_BITS-1:0]     sig_reg;
    logic [pbt_pkg::CONF_W-1:0]       conf_reg;
    logic [pbt_pkg::DLT_W-1:0]        dlt_reg;

    // Table
    logic [pbt_pkg::ENTRIES-1:0]      ent_valid_reg;
    logic [pbt_pkg::SIG_BITS-1:0]     ent_sig_reg  [pbt_pkg::ENTRIES];
    logic [pbt_pkg::CONF_W-1:0]       ent_conf_reg [pbt_pkg::ENTRIES];
    logic [pbt_pkg::OFF_BITS-1:0]     ent_off_reg  [pbt_pkg::ENTRIES];
    logic [pbt_pkg::DLT_W-1:0]        ent_dlt_reg  [pbt_pkg::ENTRIES];

    // Result slot
    logic                             out_valid_reg;
    logic                             hit_reg;
    logic [pbt_pkg::SIGF_W-1:0]       hit_sig_reg;
    logic [pbt_pkg::CONF_W-1:0]       hit_conf_reg;
    logic [pbt_pkg::DLT_W-1:0]        hit_dlt_reg;

    logic                             match_any;
    logic [pbt_pkg::IDX_BITS-1:0]     match_idx;
    logic                             free_any;
    logic [pbt_pkg::IDX_BITS-1:0]     free_idx;
    logic [pbt_pkg::IDX_BITS-1:0]     min_idx;
    logic [pbt_pkg::IDX_BITS-1:0]     wr_idx;
    logic                             is_check;
    logic                             is_update;
    logic                             is_clear;

    assign is_check  = (op_reg == pbt_pkg::OP_CHECK);
    assign is_update = (op_reg == pbt_pkg::OP_UPDATE);
    assign is_clear  = (op_reg == pbt_pkg::OP_CLEAR);

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req.operation;
            off_reg  <= pbt_pkg::block_offset(req.address);
            sig_reg  <= pbt_pkg::SIG_BITS'(32'(req.signature));
            conf_reg <= req.confidence;
            dlt_reg  <= req.delta;
        end
    end

    // Find the lowest valid entry with the same offset
    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = pbt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (ent_valid_reg[i] && (ent_off_reg[i] == off_reg))
            begin
                match_any = 1'b1;
                match_idx = pbt_pkg::IDX_BITS'(i);
            end
        end
    end

    // Find the lowest invalid entry
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = pbt_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!ent_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = pbt_pkg::IDX_BITS'(i);
            end
        end
    end

    // Lowest confidence, lowest index on ties
    always_comb
    begin
        min_idx = '0;
        for (int i = 1; i < pbt_pkg::ENTRIES; i++)
        begin
            if (ent_conf_reg[i] < ent_conf_reg[min_idx])
            begin
                min_idx = pbt_pkg::IDX_BITS'(i);
            end
        end
    end

    // Pick the update victim
    always_comb
    begin
        if (match_any)
        begin
            wr_idx = match_idx;
        end
        else if (free_any)
        begin
            wr_idx = free_idx;
        end
        else
        begin
            wr_idx = min_idx;
        end
    end

    // Table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            for (int i = 0; i < pbt_pkg::ENTRIES; i++)
            begin
                ent_sig_reg[i]  <= '0;
                ent_conf_reg[i] <= '0;
                ent_off_reg[i]  <= '0;
                ent_dlt_reg[i]  <= '0;
            end
        end
        else if (cmd.execute)
        begin
            if (is_check && match_any)
            begin
                ent_valid_reg[match_idx] <= 1'b0;
            end
            else if (is_update)
            begin
                ent_valid_reg[wr_idx] <= 1'b1;
                ent_sig_reg[wr_idx]   <= sig_reg;
                ent_conf_reg[wr_idx]  <= conf_reg;
                ent_off_reg[wr_idx]   <= off_reg;
                ent_dlt_reg[wr_idx]   <= dlt_reg;
            end
            else if (is_clear)
            begin
                ent_valid_reg <= '0;
                for (int i = 0; i < pbt_pkg::ENTRIES; i++)
                begin
                    ent_sig_reg[i]  <= '0;
                    ent_conf_reg[i] <= '0;
                    ent_off_reg[i]  <= '0;
                    ent_dlt_reg[i]  <= '0;
                end
            end
        end
    end

    // Result slot valid: set on execute, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; zero unless a check hit
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (is_check && match_any)
            begin
                hit_reg      <= 1'b1;
                hit_sig_reg  <= pbt_pkg::SIGF_W'(32'(ent_sig_reg[match_idx]));
                hit_conf_reg <= ent_conf_reg[match_idx];
                hit_dlt_reg  <= ent_dlt_reg[match_idx];
            end
            else
            begin
                hit_reg      <= 1'b0;
                hit_sig_reg  <= '0;
                hit_conf_reg <= '0;
                hit_dlt_reg  <= '0;
            end
        end
    end

    assign stat.out_hold      = out_valid_reg && !rsp.ready;
    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = hit_reg;
    assign rsp.hit_signature  = hit_sig_reg;
    assign rsp.hit_confidence = hit_conf_reg;
    assign rsp.hit_delta      = hit_dlt_reg;

    // A clear leaves no valid entry
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && is_clear |=> ent_valid_reg == '0)
        else $error("entries valid after clear");

    // A check hit consumes exactly one entry
    a_hit_consume: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && is_check && match_any |=>
        $countones(ent_valid_reg) == $countones($past(ent_valid_reg)) - 1)
        else $error("check hit did not consume one entry");

    // An update leaves its entry valid and never shrinks the table
    a_update_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && is_update |=>
        $countones(ent_valid_reg) >= $countones($past(ent_valid_reg)) &&
        ent_valid_reg != '0)
        else $error("update lost entries");

    // An executed transaction presents a result next cycle
    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid_reg)
        else $error("execute produced no result");

endmodule

/* rtl/prefetch_bootstrap_table_unit.sv */
// A request transaction is captured into the payload registers, then executed into the
// registered result slot; the controller takes no new request until it has executed the
// last one (parallel tag compare, victim select and table write in the execute state).
// Execution waits while an earlier response is still held by the consumer.
// Reset: asynchronous, clears the whole table and the controller at once; no clearing pass.
module prefetch_bootstrap_table_unit (
    input  logic      clk,
    input  logic      rst_n,
    pbt_req_if.sink   req,
    pbt_rsp_if.source rsp
);

    pbt_pkg::pbt_cmd_t  cmd;
    pbt_pkg::pbt_stat_t stat;

    // Sequencer
    pbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table and result slot
    pbt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
